[rtl/core/szpc_pkg.sv]
// Shared types, constants and helpers of the sector-zero partition classifier.
// Used by szpc_front, szpc_queue, szpc_back and the top level; depends on nothing.
package szpc_pkg;

   localparam int TableEntries = 4;
   localparam int EntryIdxW    = $clog2(TableEntries);
   localparam int QueueDepth   = 2;

   localparam logic [15:0] TableBase   = 16'd446;
   localparam logic [15:0] TableEnd    = 16'd510;
   localparam logic [15:0] MinSector   = 16'd512;

   localparam logic [7:0] JmpShort     = 8'hEB;
   localparam logic [7:0] JmpNear      = 8'hE9;
   localparam logic [7:0] SigLow       = 8'h55;
   localparam logic [7:0] SigHigh      = 8'hAA;
   localparam logic [7:0] TypeProtect  = 8'hEE;

   // Entry status codes.
   localparam logic [1:0] StatusAccepted = 2'd0;
   localparam logic [1:0] StatusEmpty    = 2'd1;
   localparam logic [1:0] StatusNotFat   = 2'd2;
   localparam logic [1:0] StatusRange    = 2'd3;

   // Record kinds.
   localparam logic RecordEntry   = 1'b0;
   localparam logic RecordSummary = 1'b1;

   // Configuration register indexes.
   localparam logic CsrBytesPerSector = 1'b0;
   localparam logic CsrDiskSectors    = 1'b1;

   localparam int RspDataW = 80;

   // Everything the back end needs to emit the records of one sector.
   typedef struct packed {
      logic [TableEntries-1:0][7:0]  types;
      logic [TableEntries-1:0][31:0] starts;
      logic [TableEntries-1:0][31:0] sizes;
      logic                          sig_ok;
      logic                          boot_ok;
   } job_type;

   function automatic logic type_is_fat(input logic [7:0] t);
      type_is_fat = (t == 8'h0B) || (t == 8'h0C) || (t == 8'h1B) ||
                    (t == 8'h1C) || (t == 8'h1E) || (t == 8'hEF);
   endfunction

endpackage

[rtl/core/szpc_front.sv]
// Front end: counts byte offsets, captures table entries and runs the boot-sector checks.
// Pushes one job per sector on its final byte. Depends on szpc_pkg.
module szpc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  logic [7:0]            data_byte,
   input  logic [15:0]           bytes_per_sector,
   output logic                  push,
   output szpc_pkg::job_type     job
);

   logic [15:0] offset_ff, offset_in;
   logic [7:0]  held_ff, held_in, held_cap;
   logic        pass_ff, pass_in, pass_cap;
   logic [1:0]  sig_ff, sig_in, sig_cap;
   logic [szpc_pkg::TableEntries-1:0][7:0]  types_ff, types_in, types_cap;
   logic [szpc_pkg::TableEntries-1:0][31:0] starts_ff, starts_in, starts_cap;
   logic [szpc_pkg::TableEntries-1:0][31:0] sizes_ff, sizes_in, sizes_cap;

   logic [15:0] pair;
   logic [15:0] rel;
   logic [15:0] final_off;
   logic [7:0]  data_dec;
   logic        in_table;
   logic        is_final;
   logic        len_ok;
   logic [szpc_pkg::EntryIdxW-1:0] idx;
   logic [3:0]  k;

   assign pair      = {data_byte, held_ff};
   assign rel       = offset_ff - szpc_pkg::TableBase;
   assign idx       = rel[4 +: szpc_pkg::EntryIdxW];
   assign k         = rel[3:0];
   assign in_table  = (offset_ff >= szpc_pkg::TableBase) && (offset_ff < szpc_pkg::TableEnd);
   assign final_off = bytes_per_sector - 16'd1;
   assign is_final  = (offset_ff == final_off);
   assign data_dec  = data_byte - 8'd1;
   // A programmed size of zero stands for 65536 bytes.
   assign len_ok    = (bytes_per_sector == 16'd0) || (bytes_per_sector >= szpc_pkg::MinSector);

   always_comb begin
      held_cap   = held_ff;
      pass_cap   = pass_ff;
      sig_cap    = sig_ff;
      types_cap  = types_ff;
      starts_cap = starts_ff;
      sizes_cap  = sizes_ff;
      case (offset_ff)
         16'd0: begin
            if (data_byte != szpc_pkg::JmpShort && data_byte != szpc_pkg::JmpNear) begin
               pass_cap = 1'b0;
            end
         end
         16'd11, 16'd14, 16'd17, 16'd19, 16'd22, 16'd36: held_cap = data_byte;
         16'd12: begin
            if (pair != bytes_per_sector || bytes_per_sector == 16'd0) begin
               pass_cap = 1'b0;
            end
         end
         16'd13: begin
            if (data_byte == 8'd0 || data_byte > 8'd128 || (data_byte & data_dec) != 8'd0) begin
               pass_cap = 1'b0;
            end
         end
         16'd15: begin
            if (pair == 16'd0) begin
               pass_cap = 1'b0;
            end
         end
         16'd16: begin
            if (data_byte == 8'd0) begin
               pass_cap = 1'b0;
            end
         end
         16'd18, 16'd20, 16'd23: begin
            if (pair != 16'd0) begin
               pass_cap = 1'b0;
            end
         end
         16'd37, 16'd38: held_cap = held_ff | data_byte;
         16'd39: begin
            if ((held_ff | data_byte) == 8'd0) begin
               pass_cap = 1'b0;
            end
         end
         16'd510: begin
            if (data_byte == szpc_pkg::SigLow) begin
               sig_cap[0] = 1'b1;
            end
         end
         16'd511: begin
            if (data_byte == szpc_pkg::SigHigh) begin
               sig_cap[1] = 1'b1;
            end
         end
         default: ;
      endcase
      if (in_table) begin
         if (k == 4'd4) begin
            types_cap[idx] = data_byte;
         end else if (k[3:2] == 2'd2) begin
            starts_cap[idx][8*k[1:0] +: 8] = data_byte;
         end else if (k[3:2] == 2'd3) begin
            sizes_cap[idx][8*k[1:0] +: 8] = data_byte;
         end
      end
   end

   always_comb begin
      job.types   = types_cap;
      job.starts  = starts_cap;
      job.sizes   = sizes_cap;
      job.sig_ok  = len_ok && (sig_cap == 2'b11);
      job.boot_ok = len_ok && (sig_cap == 2'b11) && pass_cap;
      push        = beat && is_final;
   end

   always_comb begin
      offset_in = offset_ff;
      held_in   = held_ff;
      pass_in   = pass_ff;
      sig_in    = sig_ff;
      types_in  = types_ff;
      starts_in = starts_ff;
      sizes_in  = sizes_ff;
      if (beat) begin
         if (is_final) begin
            // The sector is complete: start the next run from a clean slate.
            offset_in = 16'd0;
            held_in   = 8'd0;
            pass_in   = 1'b1;
            sig_in    = 2'b00;
            types_in  = '0;
            starts_in = '0;
            sizes_in  = '0;
         end else begin
            offset_in = offset_ff + 16'd1;
            held_in   = held_cap;
            pass_in   = pass_cap;
            sig_in    = sig_cap;
            types_in  = types_cap;
            starts_in = starts_cap;
            sizes_in  = sizes_cap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 16'd0;
         held_ff   <= 8'd0;
         pass_ff   <= 1'b1;
         sig_ff    <= 2'b00;
      end else begin
         offset_ff <= offset_in;
         held_ff   <= held_in;
         pass_ff   <= pass_in;
         sig_ff    <= sig_in;
      end
   end

   always_ff @(posedge clock) begin
      types_ff  <= types_in;
      starts_ff <= starts_in;
      sizes_ff  <= sizes_in;
   end

endmodule

[rtl/core/szpc_queue.sv]
// Short job queue between the front and back ends of the classifier.
// Holds whole sector jobs so either side can stall alone. Depends on szpc_pkg.
module szpc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  szpc_pkg::job_type     push_job,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output szpc_pkg::job_type     head_job
);

   localparam int PtrW = $clog2(szpc_pkg::QueueDepth);
   localparam int CntW = $clog2(szpc_pkg::QueueDepth + 1);

   szpc_pkg::job_type slots_ff [szpc_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full       = (count_ff == CntW'(szpc_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("job pushed into a full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && !head_valid))
      else $error("job popped from an empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(szpc_pkg::QueueDepth))
      else $error("queue count beyond depth");
`endif

endmodule

[rtl/core/szpc_back.sv]
// Back end: turns one queued sector job into four entry records and a summary record.
// Owns the registered output stage. Depends on szpc_pkg.
module szpc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  szpc_pkg::job_type             head_job,
   input  logic [63:0]                   disk_sector_count,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [szpc_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   logic [2:0] rec_ff, rec_in;
   logic       valid_ff, valid_in;
   logic [szpc_pkg::RspDataW-1:0] data_ff, data_in;
   logic       user_ff, user_in;
   logic       last_ff, last_in;

   logic       load;
   logic       is_summary;
   logic [szpc_pkg::EntryIdxW-1:0] eidx;
   logic [7:0]  etype;
   logic [31:0] estart;
   logic [31:0] esize;
   logic [32:0] eend;
   logic [1:0]  status;
   logic        any_fat;
   logic        prot;
   logic [2:0]  entry_num;

   assign load       = head_valid && (!valid_ff || rsp_tready);
   assign is_summary = (rec_ff == 3'(szpc_pkg::TableEntries));
   assign eidx       = rec_ff[szpc_pkg::EntryIdxW-1:0];
   assign etype      = head_job.types[eidx];
   assign estart     = head_job.starts[eidx];
   assign esize      = head_job.sizes[eidx];
   assign eend       = {1'b0, estart} + {1'b0, esize};
   assign entry_num  = rec_ff + 3'd1;
   assign pop        = load && is_summary;

   always_comb begin
      if (etype == 8'd0) begin
         status = szpc_pkg::StatusEmpty;
      end else if (!szpc_pkg::type_is_fat(etype)) begin
         status = szpc_pkg::StatusNotFat;
      end else if (esize == 32'd0 || {31'd0, eend} > disk_sector_count) begin
         status = szpc_pkg::StatusRange;
      end else begin
         status = szpc_pkg::StatusAccepted;
      end
   end

   always_comb begin
      any_fat = 1'b0;
      for (int i = 0; i < szpc_pkg::TableEntries; i++) begin
         if (szpc_pkg::type_is_fat(head_job.types[i])) begin
            any_fat = 1'b1;
         end
      end
      prot = head_job.sig_ok && (head_job.types[0] == szpc_pkg::TypeProtect) &&
             (disk_sector_count >= 64'd2);
   end

   always_comb begin
      rec_in   = rec_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = '0;
         if (is_summary) begin
            rec_in      = 3'd0;
            user_in     = szpc_pkg::RecordSummary;
            last_in     = 1'b1;
            data_in[69] = head_job.sig_ok;
            data_in[70] = prot;
            data_in[71] = head_job.sig_ok && any_fat;
            data_in[72] = head_job.boot_ok;
         end else begin
            rec_in          = rec_ff + 3'd1;
            user_in         = szpc_pkg::RecordEntry;
            last_in         = 1'b0;
            data_in[2:0]    = entry_num;
            data_in[4:3]    = status;
            data_in[36:5]   = estart;
            data_in[68:37]  = esize;
         end
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         rec_ff   <= rec_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

[rtl/core/sector_zero_partition_classifier.sv]
// Sector-zero partition classifier, top level: configuration registers and the
// front end, job queue and back end. Accepts one sector byte per cycle while the
// job queue is not full. The first entry record passes the job queue and the
// registered output stage after the final byte's beat; the summary follows
// the four entry records. Only sectors under five bytes slow the input.
// Reset is synchronous: 512-byte sectors, zero disk sectors, queue and offset clear.
module sector_zero_partition_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] entry_number, [4:3] entry_status, [36:5] start_lba, [68:37] size_lba,
   // [69] signature_ok, [70] protective_gpt, [71] mbr_has_fat,
   // [72] fat_boot_sector, [79:73] zero
   output logic [szpc_pkg::RspDataW-1:0] rsp_tdata,
   output logic                          rsp_tuser,   // [0] record_kind
   output logic                          rsp_tlast,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [63:0]                   csr_wdata
);

   logic [15:0] bps_ff, bps_in;
   logic [63:0] dsc_ff, dsc_in;

   logic              beat;
   logic              push;
   logic              pop;
   logic              full;
   logic              head_valid;
   szpc_pkg::job_type push_job;
   szpc_pkg::job_type head_job;

   always_comb begin
      bps_in = bps_ff;
      dsc_in = dsc_ff;
      if (csr_we) begin
         case (csr_index)
            szpc_pkg::CsrBytesPerSector: bps_in = csr_wdata[15:0];
            szpc_pkg::CsrDiskSectors:    dsc_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff <= szpc_pkg::MinSector;
         dsc_ff <= 64'd0;
      end else begin
         bps_ff <= bps_in;
         dsc_ff <= dsc_in;
      end
   end

   assign req_tready = !full;
   assign beat       = req_tvalid && req_tready;

   szpc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .beat             (beat),
      .data_byte        (req_tdata),
      .bytes_per_sector (bps_ff),
      .push             (push),
      .job              (push_job)
   );

   szpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   szpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_job          (head_job),
      .disk_sector_count (dsc_ff),
      .pop               (pop),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast)
   );

endmodule

[tb/tb.sv]
// Self-checking bench for sector_zero_partition_classifier: streams sector-zero images
// through req_*, predicts the entry and summary records and checks every rsp_* beat.
// Depends on szpc_pkg and the classifier RTL only.
`timescale 1ns / 100ps

module tb;
   import szpc_pkg::*;

   localparam int StallLimit   = 3000;
   localparam int HoldCycles   = 400;
   localparam int SettleCycles = 8;
   localparam int IdlePercent  = 13;
   localparam int MaxPrinted   = 40;

   localparam logic [7:0] TypeFat32Chs    = 8'h0B;
   localparam logic [7:0] TypeFat32Lba    = 8'h0C;
   localparam logic [7:0] TypeHidFat32Chs = 8'h1B;
   localparam logic [7:0] TypeHidFat32Lba = 8'h1C;
   localparam logic [7:0] TypeHidFat16Lba = 8'h1E;
   localparam logic [7:0] TypeEfiSystem   = 8'hEF;
   localparam logic [7:0] FatTypes [6] = '{TypeFat32Chs, TypeFat32Lba, TypeHidFat32Chs,
                                           TypeHidFat32Lba, TypeHidFat16Lba, TypeEfiSystem};
   // Boot-sector offsets whose corruption should fail one of the BPB rules.
   localparam int BpbSpots [13] = '{0, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 22, 23};

   typedef enum {SectorNoise, SectorFormed, SectorBlank} sector_fill_e;

   typedef struct {
      bit        kind;
      bit [2:0]  slot;
      bit [1:0]  status;
      bit [31:0] start_lba;
      bit [31:0] size_lba;
      bit        sig_ok;
      bit        protective;
      bit        has_fat;
      bit        boot_ok;
      bit        last;
   } sector_record_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = 8'h00;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_we = 1'b0;
   logic                csr_index = 1'b0;
   logic [63:0]         csr_wdata = 64'h0;

   logic hold_start = 1'b0;
   logic steady = 1'b0;
   int   hold_left = 0;
   int   stall_count = 0;
   int   beats_queued = 0;
   int   beats_accepted = 0;
   int   records_seen = 0;
   int   errors = 0;

   bit [7:0]       byte_q [$];
   sector_record_t record_q [$];
   bit [7:0]       sector_image [0:65535];

   // Predicted block state and configuration.
   bit [15:0] cfg_sector_size = MinSector;
   bit [63:0] cfg_disk_sectors = 64'h0;
   bit [15:0] scan_offset;
   bit [7:0]  low_byte;
   bit        bpb_ok;
   bit [1:0]  sig_seen;
   bit [7:0]  part_type [TableEntries];
   bit [31:0] part_start [TableEntries];
   bit [31:0] part_size [TableEntries];

   sector_zero_partition_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit is_fat_type(input bit [7:0] t);
      return t inside {TypeFat32Chs, TypeFat32Lba, TypeHidFat32Chs,
                       TypeHidFat32Lba, TypeHidFat16Lba, TypeEfiSystem};
   endfunction

   task automatic clear_scan();
      scan_offset = 16'h0;
      low_byte = 8'h0;
      bpb_ok = 1'b1;
      sig_seen = 2'b00;
      for (int i = 0; i < TableEntries; i++) begin
         part_type[i] = 8'h0;
         part_start[i] = 32'h0;
         part_size[i] = 32'h0;
      end
   endtask

   // Folds one sector byte into the scan state; on the final byte of the sector
   // it queues the four entry records and the summary.
   task automatic classify_byte(input bit [7:0] b);
      bit [15:0]      pair;
      bit [15:0]      final_off;
      bit [31:0]      len;
      int             rel;
      int             idx;
      int             k;
      bit             any_fat;
      bit             sig_good;
      sector_record_t rec;
      pair = {b, low_byte};
      len = (cfg_sector_size == 16'h0) ? 32'h1_0000 : {16'h0, cfg_sector_size};
      case (scan_offset)
         0: if (b != JmpShort && b != JmpNear) bpb_ok = 1'b0;
         11, 14, 17, 19, 22, 36: low_byte = b;
         12: if ({16'h0, pair} != len) bpb_ok = 1'b0;
         13: if (b == 8'h0 || b > 8'd128 || (b & (b - 8'd1)) != 8'h0) bpb_ok = 1'b0;
         15: if (pair == 16'h0) bpb_ok = 1'b0;
         16: if (b == 8'h0) bpb_ok = 1'b0;
         18, 20, 23: if (pair != 16'h0) bpb_ok = 1'b0;
         37, 38: low_byte = low_byte | b;
         39: if ((low_byte | b) == 8'h0) bpb_ok = 1'b0;
         TableEnd: if (b == SigLow) sig_seen[0] = 1'b1;
         TableEnd + 16'd1: if (b == SigHigh) sig_seen[1] = 1'b1;
         default: ;
      endcase
      if (scan_offset >= TableBase && scan_offset < TableBase + 16 * TableEntries) begin
         rel = scan_offset - TableBase;
         idx = rel >> 4;
         k = rel & 15;
         if (k == 4)
            part_type[idx] = b;
         else if (k >= 8 && k < 12)
            part_start[idx][(k % 4) * 8 +: 8] = b;
         else if (k >= 12)
            part_size[idx][(k % 4) * 8 +: 8] = b;
      end
      final_off = cfg_sector_size - 16'd1;
      if (scan_offset != final_off) begin
         scan_offset = scan_offset + 16'd1;
         return;
      end
      any_fat = 1'b0;
      for (int i = 0; i < TableEntries; i++) begin
         rec = '{default: 0};
         rec.kind = RecordEntry;
         rec.slot = 3'(i + 1);
         rec.start_lba = part_start[i];
         rec.size_lba = part_size[i];
         if (part_type[i] == 8'h0)
            rec.status = StatusEmpty;
         else if (!is_fat_type(part_type[i]))
            rec.status = StatusNotFat;
         else if (part_size[i] == 32'h0 ||
                  {32'h0, part_start[i]} + {32'h0, part_size[i]} > cfg_disk_sectors)
            rec.status = StatusRange;
         else
            rec.status = StatusAccepted;
         if (is_fat_type(part_type[i])) any_fat = 1'b1;
         record_q.push_back(rec);
      end
      sig_good = (len >= 32'(MinSector)) && (sig_seen == 2'b11);
      rec = '{default: 0};
      rec.kind = RecordSummary;
      rec.sig_ok = sig_good;
      rec.protective = sig_good && part_type[0] == TypeProtect && cfg_disk_sectors >= 64'd2;
      rec.has_fat = sig_good && any_fat;
      rec.boot_ok = sig_good && bpb_ok;
      rec.last = 1'b1;
      record_q.push_back(rec);
      clear_scan();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (errors < MaxPrinted)
         $display("record %0d: %s is %0h, expected %0h", records_seen, what, got, want);
      errors++;
   endtask

   task automatic check_record();
      sector_record_t want;
      records_seen++;
      if (record_q.size() == 0) begin
         report_mismatch("unexpected record", rsp_tdata[63:0], 64'h0);
         return;
      end
      want = record_q.pop_front();
      if (rsp_tuser !== want.kind) report_mismatch("record_kind", rsp_tuser, want.kind);
      if (rsp_tdata[2:0] !== want.slot)
         report_mismatch("entry_number", rsp_tdata[2:0], want.slot);
      if (rsp_tdata[4:3] !== want.status)
         report_mismatch("entry_status", rsp_tdata[4:3], want.status);
      if (rsp_tdata[36:5] !== want.start_lba)
         report_mismatch("start_lba", rsp_tdata[36:5], want.start_lba);
      if (rsp_tdata[68:37] !== want.size_lba)
         report_mismatch("size_lba", rsp_tdata[68:37], want.size_lba);
      if (rsp_tdata[69] !== want.sig_ok)
         report_mismatch("signature_ok", rsp_tdata[69], want.sig_ok);
      if (rsp_tdata[70] !== want.protective)
         report_mismatch("protective_gpt", rsp_tdata[70], want.protective);
      if (rsp_tdata[71] !== want.has_fat)
         report_mismatch("mbr_has_fat", rsp_tdata[71], want.has_fat);
      if (rsp_tdata[72] !== want.boot_ok)
         report_mismatch("fat_boot_sector", rsp_tdata[72], want.boot_ok);
      if (rsp_tdata[79:73] !== 7'h0) report_mismatch("padding", rsp_tdata[79:73], 64'h0);
      if (rsp_tlast !== want.last) report_mismatch("last_of_run", rsp_tlast, want.last);
   endtask

   // Sender: offers queued bytes, holding a beat until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (byte_q.size() != 0 && (steady || $urandom_range(99) >= IdlePercent)) begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_start) begin
         rsp_tready <= 1'b0;
         hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= IdlePercent;
      end
   end

   always @(posedge clock) begin : monitor
      if (reset) begin
         clear_scan();
         stall_count <= 0;
      end else begin
         // Check first so that a beat never meets records predicted at the same edge.
         if (rsp_tvalid && rsp_tready) check_record();
         if (req_tvalid && req_tready) begin
            classify_byte(req_tdata);
            beats_accepted <= beats_accepted + 1;
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            stall_count <= 0;
         end else if (stall_count >= StallLimit) begin
            $display("sector_zero_partition_classifier regression: fail");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   task automatic settle();
      do @(posedge clock);
      while (beats_accepted != beats_queued || record_q.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CsrBytesPerSector)
         cfg_sector_size = value[15:0];
      else
         cfg_disk_sectors = value;
   endtask

   task automatic queue_value(input bit [7:0] b);
      byte_q.push_back(b);
      beats_queued++;
   endtask

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) queue_value(8'($urandom));
   endtask

   // Queues image bytes from the current scan offset on; the block must be drained.
   task automatic queue_bytes(input int n);
      bit [15:0] off;
      off = scan_offset;
      for (int i = 0; i < n; i++) begin
         queue_value(sector_image[off]);
         off = off + 16'd1;
      end
   endtask

   task automatic queue_rest();
      bit [15:0] gap;
      gap = cfg_sector_size - 16'd1 - scan_offset;
      queue_bytes(int'(gap) + 1);
   endtask

   task automatic build_image(input sector_fill_e mode, input int fill_len,
                              input bit [15:0] bpb_len, input bit protect);
      bit [15:0] base;
      bit [31:0] first;
      bit [31:0] count;
      bit [31:0] bound;
      bit [7:0]  kind_byte;
      int        pick;
      for (int i = 0; i < fill_len; i++)
         sector_image[i] = (mode == SectorBlank) ? 8'h00 : 8'($urandom);
      if (mode != SectorFormed) return;
      sector_image[0] = $urandom_range(1) ? JmpShort : JmpNear;
      {sector_image[12], sector_image[11]} = bpb_len;
      sector_image[13] = 8'd1 << $urandom_range(7);
      {sector_image[15], sector_image[14]} = 16'($urandom_range(1, 65535));
      sector_image[16] = 8'($urandom_range(1, 255));
      for (int i = 17; i <= 20; i++) sector_image[i] = 8'h00;
      sector_image[22] = 8'h00;
      sector_image[23] = 8'h00;
      sector_image[36 + $urandom_range(3)] = 8'($urandom_range(1, 255));
      if ($urandom_range(99) < 40) begin
         pick = $urandom_range(13);
         if (pick == 13)
            for (int i = 36; i < 40; i++) sector_image[i] = 8'h00;
         else
            sector_image[BpbSpots[pick]] ^= 8'($urandom_range(1, 255));
      end
      bound = cfg_disk_sectors[31:0];
      for (int i = 0; i < TableEntries; i++) begin
         base = TableBase + 16'(16 * i);
         case ($urandom_range(9))
            0: kind_byte = 8'h00;
            6: kind_byte = TypeProtect;
            7: kind_byte = 8'($urandom);
            default: kind_byte = FatTypes[$urandom_range(5)];
         endcase
         if (i == 0 && protect) kind_byte = TypeProtect;
         first = $urandom;
         count = $urandom;
         // Aim at the edges of the disk bound when it fits in 32 bits.
         if (cfg_disk_sectors[63:32] == 32'h0) begin
            case ($urandom_range(4))
               1: count = 32'h0;
               2: begin
                  first = $urandom_range(bound);
                  count = bound - first;
               end
               3: begin
                  first = $urandom_range(bound);
                  count = bound - first + 32'd1;
               end
               4: begin
                  first = $urandom_range(bound);
                  count = $urandom_range(bound - first);
               end
               default: ;
            endcase
         end
         sector_image[base + 16'd4] = kind_byte;
         for (int k = 0; k < 4; k++) begin
            sector_image[base + 16'(8 + k)] = first[8 * k +: 8];
            sector_image[base + 16'(12 + k)] = count[8 * k +: 8];
         end
      end
      if ($urandom_range(99) < 85) begin
         sector_image[510] = SigLow;
         sector_image[511] = SigHigh;
      end else if ($urandom_range(1)) begin
         sector_image[510] = SigLow ^ 8'($urandom_range(1, 255));
      end else begin
         sector_image[511] = SigHigh ^ 8'($urandom_range(1, 255));
      end
   endtask

   task automatic run_sector(input sector_fill_e mode, input bit protect);
      int len;
      len = (cfg_sector_size == 16'h0) ? 65536 : int'(cfg_sector_size);
      build_image(mode, len, cfg_sector_size, protect);
      queue_rest();
      settle();
   endtask

   function automatic bit [63:0] pick_disk();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return 64'd1;
         2: return 64'd2;
         3: return '1;
         4: return {32'($urandom), 32'($urandom)};
         5: return 64'h1_0000_0000;
         default: return {32'h0, 32'($urandom)};
      endcase
   endfunction

   function automatic bit [15:0] pick_sector_size();
      case ($urandom_range(9))
         0: return 16'd511;
         1: return 16'($urandom_range(513, 1024));
         2: return 16'($urandom_range(2, 31));
         3: return 16'd1;
         4: return 16'($urandom_range(32, 510));
         default: return MinSector;
      endcase
   endfunction

   function automatic sector_fill_e pick_fill();
      int r;
      r = $urandom_range(19);
      if (r < 14) return SectorFormed;
      if (r < 17) return SectorNoise;
      return SectorBlank;
   endfunction

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: 512-byte sectors on an empty disk.
      run_sector(SectorFormed, 1'b0);
      run_sector(SectorFormed, 1'b1);

      // One-byte and three-byte sectors with extreme byte values.
      write_reg(CsrBytesPerSector, 64'd1);
      queue_value(8'h00);
      queue_value(8'hFF);
      queue_value(8'h5A);
      queue_value(8'hA5);
      settle();
      write_reg(CsrBytesPerSector, 64'd3);
      queue_value(8'hFF);
      queue_value(8'h00);
      queue_value(8'h80);
      settle();

      // Long receiver hold-off while tiny sectors keep arriving.
      write_reg(CsrBytesPerSector, 64'd1);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      queue_random(80);
      settle();
      write_reg(CsrBytesPerSector, 64'd4);
      queue_random(40);
      settle();

      // Protective entry with two and one disk sectors, then a run on zero disk sectors.
      write_reg(CsrBytesPerSector, 64'(MinSector));
      write_reg(CsrDiskSectors, 64'd2);
      run_sector(SectorFormed, 1'b1);
      write_reg(CsrDiskSectors, 64'd1);
      run_sector(SectorFormed, 1'b1);
      write_reg(CsrDiskSectors, 64'd0);
      run_sector(SectorFormed, 1'b0);

      // A stretch without idling on either side.
      steady <= 1'b1;
      write_reg(CsrDiskSectors, pick_disk());
      repeat (5) run_sector(SectorFormed, 1'b0);
      steady <= 1'b0;

      for (int i = 0; i < 18; i++) begin
         if ($urandom_range(1)) write_reg(CsrBytesPerSector, 64'(pick_sector_size()));
         if ($urandom_range(1)) write_reg(CsrDiskSectors, pick_disk());
         if (cfg_sector_size != 16'h0 && cfg_sector_size < 16'd32) begin
            queue_random(6 * int'(cfg_sector_size));
            settle();
         end else begin
            run_sector(pick_fill(), $urandom_range(9) == 0);
         end
      end

      // Largest sizes; zero stands for 65536 bytes.
      write_reg(CsrBytesPerSector, 64'hFFFF);
      write_reg(CsrDiskSectors, pick_disk());
      run_sector(SectorFormed, 1'b0);
      write_reg(CsrBytesPerSector, 64'd0);
      run_sector(SectorFormed, 1'b0);

      // Sector size grows while a sector is partly in.
      write_reg(CsrBytesPerSector, 64'(MinSector));
      write_reg(CsrDiskSectors, {32'h0, 32'($urandom)});
      build_image(SectorFormed, 600, 16'd600, 1'b0);
      queue_bytes(3);
      settle();
      write_reg(CsrBytesPerSector, 64'd600);
      queue_rest();
      settle();

      // Sector size shrinks below the current offset: the counter wraps round.
      write_reg(CsrBytesPerSector, 64'(MinSector));
      build_image(SectorFormed, 65536, 16'd5, 1'b0);
      queue_bytes(10);
      settle();
      write_reg(CsrBytesPerSector, 64'd5);
      queue_rest();
      settle();

      repeat (20) @(posedge clock);
      if (record_q.size() != 0)
         report_mismatch("records never delivered", record_q.size(), 64'h0);
      if (errors == 0)
         $display("sector_zero_partition_classifier regression: pass");
      else
         $display("sector_zero_partition_classifier regression: fail");
      $finish;
   end

endmodule

[sector_zero_partition_classifier.f]
rtl/core/szpc_pkg.sv
rtl/core/szpc_front.sv
rtl/core/szpc_queue.sv
rtl/core/szpc_back.sv
rtl/core/sector_zero_partition_classifier.sv
tb/tb.sv
